// ===== src/rrmr_pkg.sv =====
// Package for the rational rate multiply and round core: item types and rounding codes.
`timescale 1ns / 1ps
package rrmr_pkg;

  localparam int AMOUNT_WIDTH_DEF = 64;
  localparam int FIELD_WIDTH      = 64;
  localparam int MODE_WIDTH       = 3;

  typedef enum logic [MODE_WIDTH-1:0] {
    RND_HALF_AWAY = 3'd0,
    RND_HALF_EVEN = 3'd1,
    RND_HALF_UP   = 3'd2,
    RND_HALF_DOWN = 3'd3,
    RND_TO_ZERO   = 3'd4,
    RND_AWAY      = 3'd5
  } rnd_mode_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] amount;
    logic signed [FIELD_WIDTH-1:0] rate_numerator;
    logic signed [FIELD_WIDTH-1:0] rate_denominator;
    logic [MODE_WIDTH-1:0]         rounding_mode;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] scaled_amount;
    logic                          overflow;
  } out_t;

endpackage

// ===== src/rational_rate_multiply_round_core.sv =====
// Top level: pipelined multiply by a rational rate with restoring division and rounding.
//
//  channel | ports                      | handshake
//  in      | start, busy, in_data       | taken when start && !busy
//  out     | out_valid, out_data        | one-cycle strobe, no back-pressure
//
// One item may enter every cycle; busy is always low.
// Pipeline stages in order: sign stage, partial products, product sum,
// one restoring division step per dividend bit (AMOUNT_WIDTH + 64), rounding, range check.
// The division chain sets the depth. Synchronous active-low reset clears valid bits only.
`timescale 1ns / 1ps
module rational_rate_multiply_round_core #(
  parameter int AMOUNT_WIDTH = rrmr_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rrmr_pkg::in_t in_data,
  output logic          out_valid,
  output rrmr_pkg::out_t out_data
);

  localparam int FW = rrmr_pkg::FIELD_WIDTH;
  localparam int AW = AMOUNT_WIDTH;
  localparam int PW = AW + FW;
  localparam int HW = FW / 2;

  assign busy = 1'b0;

  // stage 0: magnitudes and sign
  logic          v0_r;
  logic [FW-1:0] ma_r, mn_r, md_r;
  logic          neg0_r;
  logic [rrmr_pkg::MODE_WIDTH-1:0] mode0_r;

  logic [AW-1:0] a_w, ma_w;
  logic [FW-1:0] mn_w, md_w;
  logic          na_w, nn_w, nd_w;

  always_comb begin
    a_w  = in_data.amount[AW-1:0];
    na_w = a_w[AW-1];
    ma_w = na_w ? (~a_w + 1'b1) : a_w;
    nn_w = in_data.rate_numerator[FW-1];
    mn_w = nn_w ? (~in_data.rate_numerator + 1'b1) : in_data.rate_numerator;
    nd_w = in_data.rate_denominator[FW-1];
    md_w = nd_w ? (~in_data.rate_denominator + 1'b1) : in_data.rate_denominator;
    if (md_w == '0) begin
      md_w = FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    ma_r    <= FW'(ma_w);
    mn_r    <= mn_w;
    md_r    <= md_w;
    neg0_r  <= (na_w ^ nn_w) ^ nd_w;
    mode0_r <= in_data.rounding_mode;
  end

  // stage 1: partial products
  logic            v1_r, neg1_r;
  logic [FW-1:0]   md1_r;
  logic [rrmr_pkg::MODE_WIDTH-1:0] mode1_r;
  logic [2*HW-1:0] ll_r, lh_r, hl_r, hh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    ll_r    <= ma_r[HW-1:0]  * mn_r[HW-1:0];
    lh_r    <= ma_r[HW-1:0]  * mn_r[FW-1:HW];
    hl_r    <= ma_r[FW-1:HW] * mn_r[HW-1:0];
    hh_r    <= ma_r[FW-1:HW] * mn_r[FW-1:HW];
    md1_r   <= md_r;
    neg1_r  <= neg0_r;
    mode1_r <= mode0_r;
  end

  // stage 2: product sum, feeds the division chain
  logic [2*FW-1:0] prod_w;
  assign prod_w = {ll_r} + ({lh_r, HW'(0)}) + ({hl_r, HW'(0)}) + ({hh_r, FW'(0)});

  logic          dv_r   [0:PW];
  logic          dneg_r [0:PW];
  logic [rrmr_pkg::MODE_WIDTH-1:0] dmode_r [0:PW];
  logic [FW-1:0] dmd_r  [0:PW];
  logic [FW-1:0] drem_r [0:PW];
  logic [PW-1:0] dq_r   [0:PW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v1_r;
    end
    dneg_r[0]  <= neg1_r;
    dmode_r[0] <= mode1_r;
    dmd_r[0]   <= md1_r;
    drem_r[0]  <= '0;
    dq_r[0]    <= prod_w[PW-1:0];
  end

  for (genvar k = 0; k < PW; k++) begin : g_div
    logic [FW:0] trial_w;
    logic        ge_w;
    assign trial_w = {drem_r[k], dq_r[k][PW-1]};
    assign ge_w    = trial_w >= {1'b0, dmd_r[k]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
      dneg_r[k+1]  <= dneg_r[k];
      dmode_r[k+1] <= dmode_r[k];
      dmd_r[k+1]   <= dmd_r[k];
      drem_r[k+1]  <= ge_w ? FW'(trial_w - {1'b0, dmd_r[k]}) : trial_w[FW-1:0];
      dq_r[k+1]    <= {dq_r[k][PW-2:0], ge_w};
    end
  end

  // rounding stage
  logic [FW-1:0] rem_w, md_f, half_w;
  logic [PW-1:0] q_w;
  logic          tie_w, more_w, inc_w, negf_w;

  always_comb begin
    rem_w  = drem_r[PW];
    md_f   = dmd_r[PW];
    q_w    = dq_r[PW];
    negf_w = dneg_r[PW];
    half_w = md_f >> 1;
    tie_w  = !md_f[0] && (rem_w == half_w);
    more_w = rem_w > half_w;
    case (dmode_r[PW])
      rrmr_pkg::RND_HALF_AWAY: inc_w = more_w || tie_w;
      rrmr_pkg::RND_HALF_EVEN: inc_w = more_w || (tie_w && q_w[0]);
      rrmr_pkg::RND_HALF_UP:   inc_w = more_w || (tie_w && !negf_w);
      rrmr_pkg::RND_HALF_DOWN: inc_w = more_w;
      rrmr_pkg::RND_AWAY:      inc_w = rem_w != '0;
      default:                 inc_w = 1'b0;
    endcase
  end

  logic          vr_r, negr_r;
  logic [PW:0]   qr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= 1'b0;
    end else begin
      vr_r <= dv_r[PW];
    end
    qr_r   <= {1'b0, q_w} + (PW+1)'(inc_w);
    negr_r <= negf_w;
  end

  // range check and sign
  logic [PW:0]          lim_w;
  logic                 ovf_w;
  logic [AW-1:0]        mag_w;
  logic signed [AW-1:0] sv_w;

  always_comb begin
    lim_w = ((PW+1)'(1) << (AW-1)) - (PW+1)'(!negr_r);
    ovf_w = qr_r > lim_w;
    mag_w = qr_r[AW-1:0];
    sv_w  = negr_r ? signed'(~mag_w + 1'b1) : signed'(mag_w);
  end

  rrmr_pkg::out_t out_r;
  logic           ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vr_r;
    end
    out_r.overflow      <= ovf_w;
    out_r.scaled_amount <= ovf_w ? '0 : FW'(sv_w);
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
